[design/four_track_stereo_pan_mixer_assert.svh]
// Assertion helpers for the mixer. Both sample on the rising edge of clock
// and are disabled while reset is high.
`ifndef FOUR_TRACK_STEREO_PAN_MIXER_ASSERT_SVH
`define FOUR_TRACK_STEREO_PAN_MIXER_ASSERT_SVH

`define FTSPM_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("four_track_stereo_pan_mixer: same-cycle check failed");

`define FTSPM_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("four_track_stereo_pan_mixer: next-cycle check failed");

`endif

[design/ftspm_pkg.sv]
package ftspm_pkg;

   localparam int TRACKS      = 4;
   localparam int TERMS       = TRACKS + 1;
   localparam int SIDES       = 2;
   localparam int SIDE_LEFT   = 0;
   localparam int SIDE_RIGHT  = 1;
   localparam int COEF_BITS   = 33;
   localparam int GAIN_BITS   = 16;
   localparam int MUTE_BITS   = TRACKS;
   localparam int Q_FRAC_BITS = 14;
   localparam int MIX_SHIFT   = 28;
   localparam int ACC_BITS    = 64;
   localparam int PROD_W      = 66;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic signed [17:0]         Q_ONE      = 18'sd16384;
   localparam logic signed [PROD_W-1:0]   TERM_HI    = 66'sd2305843009213693952;
   localparam logic signed [PROD_W-1:0]   TERM_LO    = -TERM_HI;
   localparam logic signed [ACC_BITS:0]   ACC_HI     = 65'sd4611686018427387904;
   localparam logic signed [ACC_BITS:0]   ACC_LO     = -ACC_HI;
   localparam logic signed [ACC_BITS:0]   ROUND_HALF = 65'sd134217728;

   typedef enum logic [2:0] {
      REG_TRACK_ONE   = 3'd0,
      REG_TRACK_TWO   = 3'd1,
      REG_TRACK_THREE = 3'd2,
      REG_TRACK_FOUR  = 3'd3,
      REG_MUTE_MASK   = 3'd4,
      REG_MASTER_GAIN = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [SIDES-1:0][TRACKS-1:0][COEF_BITS-1:0] coef;
      logic [GAIN_BITS-1:0]                        gain;
   } mix_coef_type;

   function automatic logic signed [ACC_BITS-1:0] clamp_term(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] c;
      c = v;
      if (v > TERM_HI) begin
         c = TERM_HI;
      end else if (v < TERM_LO) begin
         c = TERM_LO;
      end
      return ACC_BITS'(c);
   endfunction

   function automatic logic signed [ACC_BITS-1:0] add_clamp(
      input logic signed [ACC_BITS-1:0] acc,
      input logic signed [ACC_BITS-1:0] term);
      logic signed [ACC_BITS:0] sum;
      sum = {acc[ACC_BITS-1], acc} + {term[ACC_BITS-1], term};
      if (sum > ACC_HI) begin
         sum = ACC_HI;
      end else if (sum < ACC_LO) begin
         sum = ACC_LO;
      end
      return ACC_BITS'(sum);
   endfunction

endpackage

[design/ftspm_csr.sv]
module ftspm_csr import ftspm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready,
   output mix_coef_type        coef
);

   logic [CSR_DW-1:0]    setup_ff [TRACKS];
   logic [CSR_DW-1:0]    setup_in [TRACKS];
   logic [MUTE_BITS-1:0] mute_ff, mute_in;
   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   logic [2:0]           reg_index;
   logic                 write_en;

   logic signed [17:0] pan_ext [TRACKS];
   logic signed [17:0] factor  [SIDES][TRACKS];
   logic signed [35:0] lf_prod [SIDES][TRACKS];
   logic [SIDES-1:0][TRACKS-1:0][COEF_BITS-1:0] coef_ff, coef_in;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_AW-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      setup_in = setup_ff;
      mute_in  = mute_ff;
      gain_in  = gain_ff;
      if (write_en) begin
         unique case (reg_index) inside
            REG_TRACK_ONE, REG_TRACK_TWO, REG_TRACK_THREE, REG_TRACK_FOUR: begin
               setup_in[reg_index[1:0]] = csr_pwdata;
            end
            REG_MUTE_MASK: begin
               mute_in = csr_pwdata[MUTE_BITS-1:0];
            end
            REG_MASTER_GAIN: begin
               gain_in = csr_pwdata[GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index) inside
         REG_TRACK_ONE, REG_TRACK_TWO, REG_TRACK_THREE, REG_TRACK_FOUR: begin
            csr_prdata = setup_ff[reg_index[1:0]];
         end
         REG_MUTE_MASK: begin
            csr_prdata = CSR_DW'(mute_ff);
         end
         REG_MASTER_GAIN: begin
            csr_prdata = CSR_DW'(gain_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Level times pan factor per side is folded here; a muted track gets zero.
   always_comb begin
      for (int t = 0; t < TRACKS; t++) begin
         pan_ext[t] = {{2{setup_ff[t][31]}}, setup_ff[t][31:16]};
         factor[SIDE_LEFT][t]  = Q_ONE - pan_ext[t];
         factor[SIDE_RIGHT][t] = Q_ONE + pan_ext[t];
         for (int s = 0; s < SIDES; s++) begin
            lf_prod[s][t] = $signed({2'b00, setup_ff[t][15:0]}) * factor[s][t];
            coef_in[s][t] = mute_ff[t] ? '0 : lf_prod[s][t][COEF_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TRACKS; t++) begin
            setup_ff[t] <= CSR_DW'(16384);
         end
         mute_ff <= '0;
         gain_ff <= GAIN_BITS'(16384);
      end else begin
         setup_ff <= setup_in;
         mute_ff  <= mute_in;
         gain_ff  <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef.coef = coef_ff;
   assign coef.gain = gain_ff;

endmodule

[design/four_track_stereo_pan_mixer.sv]
// Channel    Ports                                   Direction
// request    req_valid/req_ready, five samples       in
// response   rsp_valid/rsp_ready, left and right mix out
// config     csr_psel..csr_pready, APB-style         in/out
//
// A request passes through every stage below, in order, before its response is valid.
// One request is accepted per cycle while the response side keeps up.
// Stages: input, multiply, clamp, four accumulate steps, round and saturate.
// Reset clears all valid bits and restores the register defaults.
// A stall holds each occupied stage; empty stages still fill behind it.
`include "four_track_stereo_pan_mixer_assert.svh"

module four_track_stereo_pan_mixer import ftspm_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_track_one,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_track_two,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_track_three,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_track_four,
   input  logic signed [SAMPLE_BITS-1:0] req_processed_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_AW-1:0]             csr_paddr,
   input  logic [CSR_DW-1:0]             csr_pwdata,
   output logic [CSR_DW-1:0]             csr_prdata,
   output logic                          csr_pready
);

   localparam int ST_CLAMP   = 2;
   localparam int PIPE_DEPTH = ST_CLAMP + TERMS + 1;
   localparam int ST_OUT     = PIPE_DEPTH - 1;
   localparam int MUL_W      = SAMPLE_BITS + COEF_BITS;
   localparam int PROC_W     = SAMPLE_BITS + GAIN_BITS + 1;

   localparam logic signed [ACC_BITS:0] SAT_HI = (65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1;
   localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - 65'sd1;

   mix_coef_type coef;

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in, stage_en;

   logic signed [SAMPLE_BITS-1:0] samp_ff [TERMS];
   logic signed [MUL_W-1:0]       mul_ff  [SIDES][TRACKS];
   logic signed [PROC_W-1:0]      proc_ff;
   logic signed [ACC_BITS-1:0]    acc_ff  [TERMS][SIDES];
   logic signed [ACC_BITS-1:0]    term_ff [TERMS-1][SIDES][TERMS];
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;

   function automatic logic signed [SAMPLE_BITS-1:0] finish_mix(
      input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS:0] v;
      logic signed [ACC_BITS:0] q;
      v = {acc[ACC_BITS-1], acc} + ROUND_HALF;
      q = v >>> MIX_SHIFT;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return SAMPLE_BITS'(q);
   endfunction

   ftspm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   always_comb begin
      stage_en[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         if (!stage_en[k]) begin
            valid_in[k] = valid_ff[k];
         end else if (k == 0) begin
            valid_in[k] = req_valid;
         end else begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0] && req_valid) begin
         samp_ff[0]      <= req_sample_track_one;
         samp_ff[1]      <= req_sample_track_two;
         samp_ff[2]      <= req_sample_track_three;
         samp_ff[3]      <= req_sample_track_four;
         samp_ff[TRACKS] <= req_processed_sample;
      end

      if (stage_en[1] && valid_ff[0]) begin
         for (int s = 0; s < SIDES; s++) begin
            for (int t = 0; t < TRACKS; t++) begin
               mul_ff[s][t] <= samp_ff[t] * $signed(coef.coef[s][t]);
            end
         end
         proc_ff <= samp_ff[TRACKS] * $signed({1'b0, coef.gain});
      end

      if (stage_en[ST_CLAMP] && valid_ff[ST_CLAMP-1]) begin
         for (int s = 0; s < SIDES; s++) begin
            acc_ff[0][s] <= clamp_term(PROD_W'(mul_ff[s][0]));
            for (int t = 0; t < TRACKS; t++) begin
               term_ff[0][s][t] <= clamp_term(PROD_W'(mul_ff[s][t]));
            end
            term_ff[0][s][TRACKS] <= clamp_term(PROD_W'(proc_ff) <<< Q_FRAC_BITS);
         end
      end

      for (int j = 1; j < TERMS; j++) begin
         if (stage_en[ST_CLAMP+j] && valid_ff[ST_CLAMP+j-1]) begin
            for (int s = 0; s < SIDES; s++) begin
               acc_ff[j][s] <= add_clamp(acc_ff[j-1][s], term_ff[j-1][s][j]);
            end
         end
      end

      for (int j = 1; j < TERMS - 1; j++) begin
         if (stage_en[ST_CLAMP+j] && valid_ff[ST_CLAMP+j-1]) begin
            term_ff[j] <= term_ff[j-1];
         end
      end

      if (stage_en[ST_OUT] && valid_ff[ST_OUT-1]) begin
         left_ff  <= finish_mix(acc_ff[TERMS-1][SIDE_LEFT]);
         right_ff <= finish_mix(acc_ff[TERMS-1][SIDE_RIGHT]);
      end
   end

   assign req_ready     = stage_en[0];
   assign rsp_valid     = valid_ff[ST_OUT];
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

   `FTSPM_ASSERT_IMPLY(a_ready_with_bubble, !(&valid_ff), req_ready)
   `FTSPM_ASSERT_NEXT(a_accept_fills_input, req_valid && req_ready, valid_ff[0])
   `FTSPM_ASSERT_NEXT(a_stalled_acc_holds, valid_ff[ST_CLAMP+1] && !stage_en[ST_CLAMP+1], valid_ff[ST_CLAMP+1] && $stable(acc_ff[1][SIDE_LEFT]))

endmodule
